[hw/rtl/ffra_pkg.sv]
package ffra_pkg;

  // default grid size in blocks
  localparam int GRID_W_DEF = 64;
  localparam int GRID_H_DEF = 64;

  // field widths
  localparam int REQ_W      = 9;
  localparam int POS_W      = 8;
  localparam int CFG_DATA_W = 7;
  localparam int CFG_IDX_W  = 2;

  // block geometry: 4-pixel blocks, round pixel sizes up
  localparam int BLOCK_SHIFT = 2;
  localparam int ROUND_ADD   = 3;
  localparam int BLK_W       = REQ_W + 1 - BLOCK_SHIFT;

  // common width for size compares and sums
  localparam int CMP_W = 10;

  // canvas register reset value
  localparam int CANVAS_RESET = 64;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_W = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_H = CFG_IDX_W'(1);

  // clamp a canvas register to the range 1 .. grid
  function automatic logic [CMP_W-1:0] active_size(input logic [CFG_DATA_W-1:0] size_reg,
                                                   input int grid);
    logic [CMP_W-1:0] size_ext;
    logic [CMP_W-1:0] grid_ext;
    size_ext = CMP_W'(size_reg);
    grid_ext = CMP_W'(grid);
    if (size_ext == '0) begin
      return CMP_W'(1);
    end else if (size_ext > grid_ext) begin
      return grid_ext;
    end
    return size_ext;
  endfunction

endpackage

[hw/rtl/first_fit_rect_allocator.sv]
// order: a zero-size or oversize request answers with done in the cycle after start;
// otherwise each candidate row merges bh map rows (read, then add) and scans up to cw
// columns, and marking a hit rereads and rewrites bh rows (bw, bh in blocks)
// throughput: one item at a time, busy stays high for the whole search of the map
// reset: canvas registers go to 64 blocks, the whole map reads free at once
// result: a one-cycle done pulse with placed, x_pos and y_pos; the receiver cannot stall
module first_fit_rect_allocator #(
  parameter int GRID_W_BLOCKS = ffra_pkg::GRID_W_DEF,
  parameter int GRID_H_BLOCKS = ffra_pkg::GRID_H_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [ffra_pkg::REQ_W-1:0]       req_width,
  input  logic [ffra_pkg::REQ_W-1:0]       req_height,
  output logic                             done,
  output logic                             placed,
  output logic [ffra_pkg::POS_W-1:0]       x_pos,
  output logic [ffra_pkg::POS_W-1:0]       y_pos,
  input  logic                             cfg_we,
  input  logic [ffra_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ffra_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import ffra_pkg::*;

  localparam int COL_W = (GRID_W_BLOCKS > 1) ? $clog2(GRID_W_BLOCKS) : 1;
  localparam int ROW_W = (GRID_H_BLOCKS > 1) ? $clog2(GRID_H_BLOCKS) : 1;
  localparam int CWC_W = $clog2(GRID_W_BLOCKS + 1);
  localparam int RHC_W = $clog2(GRID_H_BLOCKS + 1);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_ACC_RD  = 6'b000010,
    S_ACC_ADD = 6'b000100,
    S_SCAN    = 6'b001000,
    S_MARK_RD = 6'b010000,
    S_MARK_WR = 6'b100000
  } state_t;

  state_t                   state;
  logic [CFG_DATA_W-1:0]    canvas_w;
  logic [CFG_DATA_W-1:0]    canvas_h;
  logic [CWC_W-1:0]         cw;
  logic [RHC_W-1:0]         ch;
  logic [BLK_W-1:0]         bw;
  logic [BLK_W-1:0]         bh;
  logic [RHC_W-1:0]         by;
  logic [RHC_W-1:0]         rptr;
  logic [CWC_W-1:0]         col;
  logic [CWC_W-1:0]         run;
  logic [COL_W-1:0]         bx;
  logic [GRID_W_BLOCKS-1:0] acc;
  logic [GRID_W_BLOCKS-1:0] rd_row;
  logic [GRID_W_BLOCKS-1:0] mask;

  // request size in blocks and canvas clamp
  logic [REQ_W:0]   wsum;
  logic [REQ_W:0]   hsum;
  logic [BLK_W-1:0] bw_in;
  logic [BLK_W-1:0] bh_in;
  logic [CMP_W-1:0] cw_act;
  logic [CMP_W-1:0] ch_act;
  logic             reject;

  assign wsum   = {1'b0, req_width} + (REQ_W + 1)'(ROUND_ADD);
  assign hsum   = {1'b0, req_height} + (REQ_W + 1)'(ROUND_ADD);
  assign bw_in  = wsum[REQ_W:BLOCK_SHIFT];
  assign bh_in  = hsum[REQ_W:BLOCK_SHIFT];
  assign cw_act = active_size(canvas_w, GRID_W_BLOCKS);
  assign ch_act = active_size(canvas_h, GRID_H_BLOCKS);
  assign reject = (bw_in == '0) || (bh_in == '0) ||
                  (CMP_W'(bw_in) > cw_act) || (CMP_W'(bh_in) > ch_act);

  // row span of the current candidate
  logic [CMP_W-1:0] row_end;
  logic             last_row;

  assign row_end  = CMP_W'(by) + CMP_W'(bh);
  assign last_row = (CMP_W'(rptr) + CMP_W'(1)) == row_end;

  // shared column scan step: one map bit, run length compare
  logic             bit_used;
  logic [CMP_W-1:0] run_inc;
  logic             hit;
  logic             last_col;
  logic [CMP_W-1:0] by_inc;
  logic             row_fail;
  logic [CMP_W-1:0] bx_hit;

  assign bit_used = acc[col[COL_W-1:0]];
  assign run_inc  = CMP_W'(run) + CMP_W'(1);
  assign hit      = !bit_used && (run_inc == CMP_W'(bw));
  assign last_col = (CMP_W'(col) + CMP_W'(1)) == CMP_W'(cw);
  assign by_inc   = CMP_W'(by) + CMP_W'(1);
  assign row_fail = (by_inc + CMP_W'(bh)) > CMP_W'(ch);
  assign bx_hit   = CMP_W'(col) + CMP_W'(1) - CMP_W'(bw);

  // columns covered by the placed rectangle
  always_comb begin
    for (int i = 0; i < GRID_W_BLOCKS; i++) begin
      mask[i] = (CMP_W'(i) >= CMP_W'(bx)) && (CMP_W'(i) < CMP_W'(bx) + CMP_W'(bw));
    end
  end

  // occupancy map
  ffra_occ_mem #(
    .GRID_W_BLOCKS (GRID_W_BLOCKS),
    .GRID_H_BLOCKS (GRID_H_BLOCKS),
    .ROW_W         (ROW_W)
  ) u_occ_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rptr[ROW_W-1:0]),
    .rd_row  (rd_row),
    .wr_en   (state == S_MARK_WR),
    .wr_addr (rptr[ROW_W-1:0]),
    .wr_data (rd_row | mask)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_w <= CFG_DATA_W'(CANVAS_RESET);
      canvas_h <= CFG_DATA_W'(CANVAS_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CANVAS_W: canvas_w <= cfg_data;
        REG_CANVAS_H: canvas_h <= cfg_data;
        default: ;
      endcase
    end
  end

  // search sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cw <= CWC_W'(cw_act);
            ch <= RHC_W'(ch_act);
            bw <= bw_in;
            bh <= bh_in;
            by <= '0;
            rptr <= '0;
            acc <= '0;
            if (reject) begin
              done   <= 1'b1;
              placed <= 1'b0;
              x_pos  <= '0;
              y_pos  <= '0;
            end else begin
              state <= S_ACC_RD;
            end
          end
        end
        S_ACC_RD: begin
          state <= S_ACC_ADD;
        end
        S_ACC_ADD: begin
          acc <= acc | rd_row;
          if (last_row) begin
            col   <= '0;
            run   <= '0;
            state <= S_SCAN;
          end else begin
            rptr  <= rptr + RHC_W'(1);
            state <= S_ACC_RD;
          end
        end
        S_SCAN: begin
          if (hit) begin
            bx    <= COL_W'(bx_hit);
            rptr  <= by;
            state <= S_MARK_RD;
          end else if (last_col) begin
            if (row_fail) begin
              done   <= 1'b1;
              placed <= 1'b0;
              x_pos  <= '0;
              y_pos  <= '0;
              state  <= S_IDLE;
            end else begin
              by    <= RHC_W'(by_inc);
              rptr  <= RHC_W'(by_inc);
              acc   <= '0;
              state <= S_ACC_RD;
            end
          end else begin
            run <= bit_used ? '0 : CWC_W'(run_inc);
            col <= col + CWC_W'(1);
          end
        end
        S_MARK_RD: begin
          state <= S_MARK_WR;
        end
        S_MARK_WR: begin
          if (last_row) begin
            done   <= 1'b1;
            placed <= 1'b1;
            x_pos  <= POS_W'(CMP_W'(bx) << BLOCK_SHIFT);
            y_pos  <= POS_W'(CMP_W'(by) << BLOCK_SHIFT);
            state  <= S_IDLE;
          end else begin
            rptr  <= rptr + RHC_W'(1);
            state <= S_MARK_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);

  // a result always comes out with the sequencer back at rest
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while search still running");

  // an accepted item either starts a search or answers at once
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> (busy || done))
    else $error("accepted item neither searched nor answered");

  // the column scan stays inside the active canvas
  assert property (@(posedge clk) disable iff (rst) (state == S_SCAN) |-> (col < cw))
    else $error("column scan beyond canvas width");

  // marking only touches rows of the placed rectangle
  assert property (@(posedge clk) disable iff (rst)
    (state == S_MARK_WR) |-> ((rptr >= by) && (CMP_W'(rptr) < row_end)))
    else $error("mark write outside placed rows");

endmodule

[hw/rtl/ffra_occ_mem.sv]
module ffra_occ_mem #(
  parameter int GRID_W_BLOCKS = ffra_pkg::GRID_W_DEF,
  parameter int GRID_H_BLOCKS = ffra_pkg::GRID_H_DEF,
  parameter int ROW_W         = (GRID_H_BLOCKS > 1) ? $clog2(GRID_H_BLOCKS) : 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [ROW_W-1:0]         rd_addr,
  output logic [GRID_W_BLOCKS-1:0] rd_row,
  input  logic                     wr_en,
  input  logic [ROW_W-1:0]         wr_addr,
  input  logic [GRID_W_BLOCKS-1:0] wr_data
);

  // occupancy rows, one bit per block, 1 = used
  logic [GRID_W_BLOCKS-1:0] mem [GRID_H_BLOCKS];
  logic [GRID_H_BLOCKS-1:0] row_valid;
  logic [GRID_W_BLOCKS-1:0] rd_data;
  logic                     rd_vld;

  // row array write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // per-row valid bits, cleared at reset so the map reads as free
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_vld    <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      rd_vld <= row_valid[rd_addr];
    end
  end

  // a row never written reads as all free
  assign rd_row = rd_vld ? rd_data : '0;

endmodule

[verif/first_fit_rect_allocator_checker.sv]
module first_fit_rect_allocator_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic                             busy,
  input  logic [ffra_pkg::REQ_W-1:0]       req_width,
  input  logic [ffra_pkg::REQ_W-1:0]       req_height,
  input  logic                             done,
  input  logic                             placed,
  input  logic [ffra_pkg::POS_W-1:0]       x_pos,
  input  logic [ffra_pkg::POS_W-1:0]       y_pos,
  input  logic                             cfg_we,
  input  logic [ffra_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ffra_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int unsigned                      mismatches,
  output int unsigned                      pending,
  output int unsigned                      placements
);
  timeunit 1ns;
  timeprecision 1ps;

  import ffra_pkg::*;

  localparam int GRID_W = GRID_W_DEF;
  localparam int GRID_H = GRID_H_DEF;
  localparam int SLOTS  = 16;

  typedef struct packed {
    logic             placed;
    logic [POS_W-1:0] x_pos;
    logic [POS_W-1:0] y_pos;
  } spot_t;

  // shadow of the block: canvas registers and the occupancy map, 1 = used
  logic [CFG_DATA_W-1:0] canvas_w_reg;
  logic [CFG_DATA_W-1:0] canvas_h_reg;
  logic [GRID_W-1:0]     occupancy [GRID_H];

  // ring of expected results, oldest at rd_slot
  spot_t                 expected_spots [SLOTS];
  int unsigned           rd_slot;
  int unsigned           wr_slot;
  int unsigned           queued;

  // register value to usable span: zero means one block, large values stop at the grid
  function automatic int unsigned canvas_span(input logic [CFG_DATA_W-1:0] reg_val,
                                              input int unsigned grid);
    if (reg_val == '0) return 1;
    if (int'(reg_val) > grid) return grid;
    return reg_val;
  endfunction

  // first-fit search in row-major order, marks the area on a hit
  task automatic first_fit(input logic [REQ_W-1:0] w, input logic [REQ_W-1:0] h,
                           output spot_t spot);
    int unsigned       cw, ch, bw, bh, by, bx, r;
    logic [GRID_W-1:0] merged, mask;
    spot_t             s;
    s = '0;
    cw = canvas_span(canvas_w_reg, GRID_W);
    ch = canvas_span(canvas_h_reg, GRID_H);
    bw = (int'(w) + 3) >> 2;
    bh = (int'(h) + 3) >> 2;
    if (bw != 0 && bh != 0 && bw <= cw && bh <= ch) begin
      mask = (bw >= GRID_W) ? '1 : ((GRID_W'(1) << bw) - GRID_W'(1));
      for (by = 0; by + bh <= ch && !s.placed; by++) begin
        // a column is blocked if any covered row uses it
        merged = '0;
        for (r = 0; r < bh; r++) merged |= occupancy[by + r];
        for (bx = 0; bx + bw <= cw && !s.placed; bx++) begin
          if (((merged >> bx) & mask) == '0) begin
            s.placed = 1'b1;
            s.x_pos = POS_W'(bx << 2);
            s.y_pos = POS_W'(by << 2);
            for (r = by; r < by + bh; r++) occupancy[r] |= mask << bx;
          end
        end
      end
    end
    spot = s;
  endtask

  // watch config writes, accepted items and result strobes
  always @(posedge clk) begin
    spot_t want, got;
    if (rst) begin
      canvas_w_reg = CFG_DATA_W'(CANVAS_RESET);
      canvas_h_reg = CFG_DATA_W'(CANVAS_RESET);
      for (int i = 0; i < GRID_H; i++) occupancy[i] = '0;
      rd_slot = 0;
      wr_slot = 0;
      queued  = 0;
    end else begin
      // results come back in order, one per item
      if (done) begin
        got = '{placed, x_pos, y_pos};
        if (queued == 0) begin
          $error("unexpected result: placed %0d x_pos %0d y_pos %0d",
                 got.placed, got.x_pos, got.y_pos);
          mismatches++;
        end else begin
          want = expected_spots[rd_slot];
          rd_slot = (rd_slot + 1) % SLOTS;
          queued--;
          if (got.placed !== want.placed) begin
            $error("placed: expected %0d, got %0d", want.placed, got.placed);
            mismatches++;
          end
          if (got.x_pos !== want.x_pos) begin
            $error("x_pos: expected %0d, got %0d", want.x_pos, got.x_pos);
            mismatches++;
          end
          if (got.y_pos !== want.y_pos) begin
            $error("y_pos: expected %0d, got %0d", want.y_pos, got.y_pos);
            mismatches++;
          end
        end
      end
      // spare indexes are ignored
      if (cfg_we) begin
        case (cfg_index)
          REG_CANVAS_W: canvas_w_reg = cfg_data;
          REG_CANVAS_H: canvas_h_reg = cfg_data;
          default: ;
        endcase
      end
      // accepted item
      if (start && !busy) begin
        first_fit(req_width, req_height, want);
        if (want.placed) placements++;
        if (queued == SLOTS) begin
          $error("too many items waiting for results: %0d", queued);
          mismatches++;
        end else begin
          expected_spots[wr_slot] = want;
          wr_slot = (wr_slot + 1) % SLOTS;
          queued++;
        end
      end
    end
    pending = queued;
  end

endmodule

[verif/first_fit_rect_allocator_tb.sv]
module first_fit_rect_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ffra_pkg::*;

  // indexes past the two canvas registers, written to check they are ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);
  localparam int NUM_PHASES = 10;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [REQ_W-1:0]      req_width = '0;
  logic [REQ_W-1:0]      req_height = '0;
  logic                  done;
  logic                  placed;
  logic [POS_W-1:0]      x_pos;
  logic [POS_W-1:0]      y_pos;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned placements;
  int unsigned sent;
  int unsigned idle_pct;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  first_fit_rect_allocator dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req_width  (req_width),
    .req_height (req_height),
    .done       (done),
    .placed     (placed),
    .x_pos      (x_pos),
    .y_pos      (y_pos),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  first_fit_rect_allocator_checker placement_check (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req_width  (req_width),
    .req_height (req_height),
    .done       (done),
    .placed     (placed),
    .x_pos      (x_pos),
    .y_pos      (y_pos),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending),
    .placements (placements)
  );

  // present one item and hold it until the block takes it
  task automatic request(input int unsigned w, input int unsigned h);
    @(negedge clk);
    start <= 1'b1;
    req_width <= REQ_W'(w);
    req_height <= REQ_W'(h);
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  task automatic gap(input int unsigned cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // wait until every item has its result and the block is idle
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0 || busy) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(negedge clk);
    start <= 1'b0;
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly small blocks that fit, some up to past the canvas, a few anything at all
  function automatic int unsigned pick_dim(input int unsigned span);
    int unsigned roll, blocks;
    roll = $urandom_range(0, 99);
    if (roll < 5) return $urandom_range(0, (1 << REQ_W) - 1);
    if (roll < 15) return $urandom_range(1, span * 4 + 8);
    blocks = $urandom_range(1, (span < 6) ? span : 6);
    return (blocks - 1) * 4 + $urandom_range(1, 4);
  endfunction

  function automatic int unsigned span_of(input int unsigned reg_val, input int unsigned grid);
    if (reg_val == 0) return 1;
    return (reg_val > grid) ? grid : reg_val;
  endfunction

  initial begin
    static int unsigned dir_w [20] = '{0, 9, 0, 511, 4, 257, 1, 4, 5, 256,
                                       4, 256, 3, 8, 252, 256, 128, 192, 511, 255};
    static int unsigned dir_h [20] = '{9, 0, 0, 4, 511, 1, 1, 4, 5, 4,
                                       256, 256, 7, 2, 1, 1, 128, 36, 511, 3};
    static int unsigned phase_w [NUM_PHASES] = '{0, 127, 6, 12, 20, 24, 1, 40, 64, 64};
    static int unsigned phase_h [NUM_PHASES] = '{0, 1, 6, 12, 10, 24, 64, 40, 48, 64};
    static int unsigned phase_n [NUM_PHASES] = '{15, 15, 200, 250, 220, 200, 40, 100,
                                                 80, 60};
    int unsigned span_w, span_h;

    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // directed: zero sizes, oversize, rounding, full-width and full-height spans
    idle_pct = 30;
    for (int i = 0; i < 20; i++) begin
      if ($urandom_range(0, 99) < idle_pct) gap($urandom_range(1, 3));
      request(dir_w[i], dir_h[i]);
    end

    // random phases over a range of canvas settings, last one without idling
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      write_reg(REG_CANVAS_W, phase_w[p]);
      write_reg(REG_CANVAS_H, phase_h[p]);
      write_reg((p % 2 == 0) ? REG_SPARE_A : REG_SPARE_B, $urandom_range(0, 127));
      span_w = span_of(phase_w[p], GRID_W_DEF);
      span_h = span_of(phase_h[p], GRID_H_DEF);
      case ($urandom_range(0, 2))
        0: idle_pct = 0;
        1: idle_pct = 20;
        default: idle_pct = 50;
      endcase
      if (p == NUM_PHASES - 1) idle_pct = 0;
      for (int i = 0; i < phase_n[p]; i++) begin
        // one full drain in the middle of a phase
        if (p == 3 && i == 100) settle();
        if ($urandom_range(0, 99) < idle_pct) gap($urandom_range(1, 3));
        request(pick_dim(span_w), pick_dim(span_h));
      end
    end

    settle();
    repeat (64) @(negedge clk);
    $display("ran %0d requests (%0d placed) over %0d canvas settings", sent, placements,
             NUM_PHASES + 1);
    $display("covered zero and oversize requests, clamped canvas registers, spare indexes");
    if (mismatches == 0 && pending == 0) begin
      $display("first_fit_rect_allocator regression: pass");
    end else begin
      $display("first_fit_rect_allocator regression: fail");
    end
    $finish;
  end

  // hang guard
  initial begin
    #250_000_000;
    $display("first_fit_rect_allocator regression: fail");
    $finish;
  end

endmodule
